[hdl/lfcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter package
// Shared widths, register indexes, reset values, control types and the
// fixed-point helpers used by the comb filter modules.
// ----------------------------------------------------------------------------
package lfcf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DLEN_W     = 13;
	localparam int GAIN_W     = 15;
	localparam int PROD_W     = 32;
	localparam int RND_W      = 17;
	localparam int SUM_W      = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

	localparam logic [DLEN_W-1:0] DELAY_LENGTH_RST  = 13'd2048;
	localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST  = 15'd16384;
	localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 15'd26214;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIX,
		ST_FB,
		ST_WR
	} lfcf_state_t;

	typedef struct packed {
		logic accept;
		logic mix;
		logic mul_fb;
		logic wr;
		logic clr;
	} lfcf_cmd_t;

	typedef struct packed {
		logic clr_last;
	} lfcf_status_t;

	// Rounds a Q1.15 product to the nearest integer, halves toward +infinity.
	function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + 32'sd16384;
		return t[PROD_W-1:PROD_W-RND_W];
	endfunction

	// Adds a sample and a rounded product, saturating to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] sat_add(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [RND_W-1:0] b
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s > 18'sd32767) begin
			return 16'sh7fff;
		end else if (s < -18'sd32768) begin
			return 16'sh8000;
		end
		return s[SAMPLE_W-1:0];
	endfunction

endpackage

[hdl/lfcf_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter input channel
// Valid/ready channel carrying one input sample per beat.
// ----------------------------------------------------------------------------
interface lfcf_in_if;
	import lfcf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);

endinterface

[hdl/lfcf_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter output channel
// Valid/ready channel carrying one delayed sample per beat.
// ----------------------------------------------------------------------------
interface lfcf_out_if;
	import lfcf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);

endinterface

[hdl/lfcf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter controller
// Sequences the clearing pass and the four steps of each sample, and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module lfcf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lfcf_pkg::lfcf_status_t status,
	output lfcf_pkg::lfcf_cmd_t  cmd
);
	import lfcf_pkg::*;

	lfcf_state_t state_q;
	lfcf_state_t state_d;
	logic        out_valid_q;
	logic        mix_ok;

	assign mix_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (mix_ok) begin
					state_d = ST_FB;
				end
			end
			ST_FB: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_MIX: begin
				cmd.mix = mix_ok;
			end
			ST_FB: begin
				cmd.mul_fb = 1'b1;
			end
			ST_WR: begin
				cmd.wr = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mix) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_MIX)
		else $error("accepted beat did not move to the mix step");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("input ready during clearing pass");

	a_mix_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |=> out_valid_q)
		else $error("mix step did not present an output beat");

	a_stall_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MIX && !mix_ok |=> state_q == ST_MIX)
		else $error("mix step overwrote an output beat not yet taken");

endmodule

[hdl/lfcf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter datapath
// Configuration registers, delay memory, ring position, lowpass state and a
// shared Q1.15 multiplier used for both the damping and feedback products.
// ----------------------------------------------------------------------------
module lfcf_dp #(
	parameter int MAX_DELAY_LEN = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lfcf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lfcf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [lfcf_pkg::SAMPLE_W-1:0]   sample_in,
	output logic signed [lfcf_pkg::SAMPLE_W-1:0]   sample_out,
	input  lfcf_pkg::lfcf_cmd_t                    cmd,
	output lfcf_pkg::lfcf_status_t                 status
);
	import lfcf_pkg::*;

	localparam int AW = $clog2(MAX_DELAY_LEN);
	localparam int CW = (DLEN_W > AW + 1) ? DLEN_W : AW + 1;

	logic [DLEN_W-1:0]          dlen_q;
	logic [GAIN_W-1:0]          damp_q;
	logic [GAIN_W-1:0]          fb_q;
	logic [CW-1:0]              dlen_ext;
	logic [AW-1:0]              len_m1;
	logic [AW-1:0]              ring_q;
	logic [AW-1:0]              pos_c;
	logic [AW-1:0]              pos_q;
	logic [AW-1:0]              clr_q;
	logic signed [SAMPLE_W-1:0] mem [MAX_DELAY_LEN];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] lp_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [GAIN_W-1:0]          gain_c;
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic signed [SAMPLE_W-1:0] mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q <= DELAY_LENGTH_RST;
			damp_q <= DAMPING_GAIN_RST;
			fb_q   <= FEEDBACK_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:  dlen_q <= cfg_data[DLEN_W-1:0];
				REG_DAMPING_GAIN:  damp_q <= cfg_data[GAIN_W-1:0];
				REG_FEEDBACK_GAIN: fb_q   <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign dlen_ext = CW'(dlen_q);

	always_comb begin
		if (dlen_q == '0) begin
			len_m1 = '0;
		end else if (dlen_ext > CW'(MAX_DELAY_LEN)) begin
			len_m1 = AW'(MAX_DELAY_LEN - 1);
		end else begin
			len_m1 = AW'(dlen_ext - CW'(1));
		end
	end

	assign pos_c  = (ring_q > len_m1) ? len_m1 : ring_q;
	assign gain_c = cmd.mul_fb ? fb_q : damp_q;

	assign mem_we = cmd.clr || cmd.wr;
	assign mem_wa = cmd.clr ? clr_q : pos_q;
	assign mem_wd = cmd.clr ? '0 : sat_add(x_q, qround(prod_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.accept) begin
			rd_q <= mem[pos_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= sample_in;
			pos_q <= pos_c;
		end
		if (cmd.accept || cmd.mul_fb) begin
			prod_q <= lp_q * $signed({1'b0, gain_c});
		end
		if (cmd.mix) begin
			out_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			lp_q   <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.mix) begin
				lp_q <= sat_add(rd_q, qround(prod_q));
			end
			if (cmd.wr) begin
				ring_q <= (pos_q == '0) ? len_m1 : pos_q - AW'(1);
			end
		end
	end

	assign status.clr_last = (clr_q == AW'(MAX_DELAY_LEN - 1));
	assign sample_out      = out_q;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> pos_q <= len_m1)
		else $error("write position beyond delay length");

	a_ring_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> ring_q <= len_m1)
		else $error("ring position stepped beyond delay length");

	a_ring_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr && pos_q != '0 |=> ring_q == $past(pos_q) - AW'(1))
		else $error("ring position did not step down by one");

endmodule

[hdl/lowpass_feedback_comb_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowpass feedback comb filter
// Reverb comb with a one-pole lowpass in its feedback loop, Q1.15 arithmetic.
// ----------------------------------------------------------------------------
// Each input beat returns the delay-line word at the current position as one
// output beat, updates the lowpass state and writes the new loop value back to
// the same slot. A sample steps through the accept, mix, feedback and write
// steps before the next ready, as the single multiplier is shared between the
// damping and feedback products. The output beat is held in its own register;
// if it is still waiting when the next sample reaches its mix step, that
// sample holds there until the output beat is taken. After reset the block
// clears every word of the delay memory before accepting its first sample;
// configuration writes are taken at any time but should be made only while
// the block is idle.
// ----------------------------------------------------------------------------
module lowpass_feedback_comb_filter #(
	parameter int MAX_DELAY_LEN = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lfcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfcf_pkg::CFG_DATA_W-1:0] cfg_data,
	lfcf_in_if.sink                         upstream,
	lfcf_out_if.source                      downstream
);
	import lfcf_pkg::*;

	lfcf_cmd_t    cmd;
	lfcf_status_t status;

	lfcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (upstream.valid),
		.in_ready  (upstream.ready),
		.out_valid (downstream.valid),
		.out_ready (downstream.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lfcf_dp #(
		.MAX_DELAY_LEN (MAX_DELAY_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (upstream.sample_in),
		.sample_out (downstream.sample_out),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
